/* hdl/subgraph_degree_sequence_macros.svh */
// Assertion macros shared by the subgraph degree sequence block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SUBGRAPH_DEGREE_SEQUENCE_MACROS_SVH
`define SUBGRAPH_DEGREE_SEQUENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sds_pkg.sv */
package sds_pkg;

    localparam int SLOTS  = 8;
    localparam int DEG_W  = 3;
    localparam int CNT_W  = 4;
    localparam int ADJ_W  = 28;
    localparam int MARK_W = 3;
    localparam int SORT_W = SLOTS * DEG_W;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] NODES_RESET = 4'd8;

    // Register index as decoded from paddr[ADDR_W-1:2].
    localparam logic [0:0] REG_NODES_IN_USE = 1'b0;

    typedef logic [DEG_W-1:0] deg_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        deg_t [SLOTS-1:0]  deg;
        logic [MARK_W-1:0] mark;
        cnt_t              n;
    } deg_stage_t;

    typedef struct packed {
        cnt_t [SLOTS-1:0] cum;
        deg_t             mdeg;
        logic             iso;
        cnt_t             n;
    } hist_stage_t;

    typedef struct packed {
        logic [SORT_W-1:0] sorted;
        deg_t              mdeg;
        logic              iso;
        cnt_t              n;
    } result_t;

    // Position of the edge between vertices lo < hi in the adjacency word.
    function automatic int edge_bit(input int hi, input int lo);
        return hi * (hi - 1) / 2 + lo;
    endfunction

endpackage

/* hdl/sds_degree.sv */
module sds_degree
    import sds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ADJ_W-1:0]  adj_bits,
    input  logic [MARK_W-1:0] marked_vertex,
    input  cnt_t              nodes,
    output logic              out_valid,
    input  logic              out_ready,
    output deg_stage_t        out_data
);

    logic       valid_reg;
    deg_stage_t data_reg;
    deg_stage_t data_next;

    // Each vertex counts its edges to the other vertices in use.
    always_comb
    begin
        data_next.mark = marked_vertex;
        data_next.n    = nodes;
        for (int v = 0; v < SLOTS; v++)
        begin
            data_next.deg[v] = '0;
            for (int u = 0; u < SLOTS; u++)
            begin
                if (u != v && CNT_W'(u) < nodes && CNT_W'(v) < nodes)
                begin
                    data_next.deg[v] = data_next.deg[v] + DEG_W'(
                        adj_bits[(u > v) ? edge_bit(u, v) : edge_bit(v, u)]);
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/sds_hist.sv */
module sds_hist
    import sds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  deg_stage_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hist_stage_t out_data
);

    logic        valid_reg;
    hist_stage_t data_reg;
    hist_stage_t data_next;

    // cum[d] counts the vertices in use whose degree is at most d.
    always_comb
    begin
        data_next.n = in_data.n;
        for (int d = 0; d < SLOTS; d++)
        begin
            data_next.cum[d] = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (CNT_W'(i) < in_data.n && in_data.deg[i] <= DEG_W'(d))
                begin
                    data_next.cum[d] = data_next.cum[d] + 1'b1;
                end
            end
        end
        data_next.iso  = (data_next.cum[0] != '0);
        data_next.mdeg = ({1'b0, in_data.mark} < in_data.n) ? in_data.deg[in_data.mark] : '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/sds_sort.sv */
module sds_sort
    import sds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hist_stage_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    deg_t    slot;

    // Slot k of the ascending sequence holds the number of degree values d
    // below the top one whose running count cum[d] does not pass k.
    always_comb
    begin
        data_next.mdeg   = in_data.mdeg;
        data_next.iso    = in_data.iso;
        data_next.n      = in_data.n;
        data_next.sorted = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            slot = '0;
            for (int d = 0; d < SLOTS - 1; d++)
            begin
                if (in_data.cum[d] <= CNT_W'(k))
                begin
                    slot = slot + 1'b1;
                end
            end
            if (CNT_W'(k) < in_data.n)
            begin
                data_next.sorted[k*DEG_W +: DEG_W] = slot;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/subgraph_degree_sequence.sv */
// Degree sequence of a small undirected subgraph with one marked vertex.
// Input stream: s_axis_tdata carries the lower-triangle edge bits and the
// marked vertex index. Output stream: m_axis_tdata carries the ascending
// degree sequence in 3-bit slots, the marked vertex's degree and a flag
// that is set when some vertex in use has no edges.
// The APB port holds one register, nodes_in_use, at address 0; it must be
// written only while no request is in flight, a rule the block leaves to the user.
// The datapath is three register stages: per-vertex degree count,
// cumulative degree histogram, and slot assembly. The result of a request
// is registered in each of these stages in turn before it is presented;
// one request can be accepted every cycle while the receiver keeps
// m_axis_tready high.
// Each stage holds its request while the stage after it is full, so a
// stalled receiver fills the pipeline and then deasserts s_axis_tready;
// nothing is dropped or repeated. Reset empties the pipeline and sets
// nodes_in_use to 8.
module subgraph_degree_sequence
    import sds_pkg::*;
#(
    parameter int MAX_NODES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [27:0] adj_bits, [30:28] marked_vertex, [31] zero
    input  logic [31:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [23:0] sorted_degrees, [26:24] marked_degree, [27] has_isolated, [31:28] zero
    output logic [31:0]       m_axis_tdata
);

`include "subgraph_degree_sequence_macros.svh"

    localparam int   NODE_LIM_INT = (MAX_NODES < SLOTS) ? MAX_NODES : SLOTS;
    localparam cnt_t NODE_LIM     = CNT_W'(NODE_LIM_INT);

    cnt_t        nodes_reg;
    cnt_t        nodes_eff;
    logic        reg_sel;
    logic        s1_valid;
    logic        s1_ready;
    deg_stage_t  s1_data;
    logic        s2_valid;
    logic        s2_ready;
    hist_stage_t s2_data;
    result_t     result;
    logic        sorted_ok;
    logic        in_fire;
    logic        iso_ok;
    logic        mdeg_ok;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_NODES_IN_USE);
    assign prdata  = reg_sel ? {{(DATA_W-CNT_W){1'b0}}, nodes_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= NODES_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            nodes_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign nodes_eff = (nodes_reg > NODE_LIM) ? NODE_LIM : nodes_reg;

    sds_degree u_degree
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .adj_bits      (s_axis_tdata[ADJ_W-1:0]),
        .marked_vertex (s_axis_tdata[ADJ_W +: MARK_W]),
        .nodes         (nodes_eff),
        .out_valid     (s1_valid),
        .out_ready     (s1_ready),
        .out_data      (s1_data)
    );

    sds_hist u_hist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sds_sort u_sort
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = {4'b0000, result.iso, result.mdeg, result.sorted};

    // Slots in use must never decrease from one to the next.
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 1; k < SLOTS; k++)
        begin
            if (CNT_W'(k) < result.n &&
                result.sorted[k*DEG_W +: DEG_W] < result.sorted[(k-1)*DEG_W +: DEG_W])
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign iso_ok  = (result.n == '0) || (result.iso == (result.sorted[DEG_W-1:0] == '0));
    assign mdeg_ok = (result.mdeg == '0) || ({1'b0, result.mdeg} < result.n);

    `SDS_ASSERT_NEXT(a_accept_fills_stage1, in_fire, s1_valid, "request lost at stage one")
    `SDS_ASSERT_NOW(a_sorted_ascending, m_axis_tvalid, sorted_ok, "degrees out of order")
    `SDS_ASSERT_NOW(a_isolated_matches_slot0, m_axis_tvalid, iso_ok, "isolated flag mismatch")
    `SDS_ASSERT_NOW(a_marked_degree_range, m_axis_tvalid, mdeg_ok, "marked degree too large")

endmodule
